// ===== hdl/rsos_pkg.sv =====
// ----------------------------------------------------------------------------
// rsos_pkg
// Shared widths, constants and record codes for the range sweep object
// segmenter and its serial divider.
// ----------------------------------------------------------------------------
package rsos_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int ANGLE_W  = 8;
   localparam int SUM_W    = 24;
   localparam int NUM_W    = 7;
   localparam int AVG_W    = 16;
   localparam int WIDTH_W  = 18;

   // sweep length in samples, 2 to 256
   localparam int SWEEP_SAMPLES = 181;
   localparam logic [ANGLE_W:0] SWEEP_LIMIT = (ANGLE_W + 1)'(SWEEP_SAMPLES);

   // pi/180 as an unsigned q24 fraction, rounded half up
   localparam int DEG_RAD_W = 19;
   localparam logic [DEG_RAD_W-1:0] DEG_TO_RAD_Q24 = DEG_RAD_W'(292818);
   localparam int FRAC_BITS = 24;

   // avg * span, then scaled by the q24 constant
   localparam int SPAN_PROD_W  = AVG_W + ANGLE_W;
   localparam int SCALE_PROD_W = SPAN_PROD_W + DEG_RAD_W;
   localparam logic [SCALE_PROD_W:0] ROUND_HALF = (SCALE_PROD_W + 1)'(1) << (FRAC_BITS - 1);
   localparam int ROUNDED_W = SCALE_PROD_W + 1 - FRAC_BITS;

   // saturation limits
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [AVG_W-1:0]   AVG_MAX   = {AVG_W{1'b1}};
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};
   localparam logic [NUM_W-1:0]   COUNT_MAX = {NUM_W{1'b1}};

   // register reset value
   localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(720);

   // serial divider: one quotient bit per cycle over the sum
   localparam int DIV_STEPS = SUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // record kinds on the result channel
   localparam logic KIND_OBJECT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // stream and register port widths
   localparam int REQ_DATA_W = SAMPLE_W + ANGLE_W;
   localparam int RSP_BITS_W = NUM_W + 3 * ANGLE_W + AVG_W + WIDTH_W + 2 * NUM_W;
   localparam int RSP_DATA_W = ((RSP_BITS_W + 7) / 8) * 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index of the threshold
   localparam logic REG_NEAR_THRESHOLD = 1'b0;

endpackage

// ===== hdl/rsos_div.sv =====
// ----------------------------------------------------------------------------
// rsos_div
// Restoring divider: distance sum by run span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsos_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsos_pkg::SUM_W-1:0]       dividend,
   input  logic [rsos_pkg::ANGLE_W-1:0]     divisor,
   output logic                             done,
   output logic [rsos_pkg::SUM_W-1:0]       quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [rsos_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [rsos_pkg::SUM_W-1:0]        quo_ff, quo_in;
   logic [rsos_pkg::ANGLE_W-1:0]      rem_ff, rem_in;
   logic [rsos_pkg::ANGLE_W-1:0]      dvs_ff, dvs_in;
   logic [rsos_pkg::ANGLE_W:0]        trial;
   logic [rsos_pkg::ANGLE_W:0]        diff;
   logic                              fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[rsos_pkg::SUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // sequencing of the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[rsos_pkg::SUM_W-2:0], fits};
         rem_in = fits ? diff[rsos_pkg::ANGLE_W-1:0] : trial[rsos_pkg::ANGLE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rsos_pkg::DIV_CNT_W'(rsos_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/range_sweep_object_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// range_sweep_object_segmenter_unit
// Splits a range sweep into runs of near samples and reports each closed run
// with its angles, average distance and linear width, plus a sweep summary.
// ----------------------------------------------------------------------------
//
// channel  direction  signals                      transaction
// req      in         req_tvalid/tready/tdata/tlast one range sample
// rsp      out        rsp_tvalid/tready/tdata/tuser/tlast  object record or summary
// csr      in/out     csr_psel/penable/pwrite/...  near_threshold write or read
//
// a sample that closes a run is accepted, passes the serial divider (24
// quotient bits, one per cycle, then its done flag), then multiply, scale
// and round, and then loads the result register; a closing sample that
// also ends the sweep then loads the summary as well.
// other samples finish once accepted, or load the summary if they end the sweep.
// req_tready is low while a sample is at work; a held result stalls the
// sequencer only when the next result must be loaded.
// reset is synchronous: threshold returns to 720 and the sweep state clears.
//
module range_sweep_object_segmenter_unit (
   input  logic                                clock,
   input  logic                                reset,
   // [15:0] sample_distance, [23:16] sweep_angle
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rsos_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   // [6:0] object_number, [14:7] start_angle, [22:15] end_angle,
   // [30:23] center_angle, [46:31] average_distance, [64:47] linear_width,
   // [71:65] objects_found, [78:72] narrowest_number, [79] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rsos_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] record_kind
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsos_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rsos_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rsos_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_OBJ   = 3'd5;
   localparam logic [2:0] S_SUM   = 3'd6;

   localparam int A_W = rsos_pkg::ANGLE_W;
   localparam int N_W = rsos_pkg::NUM_W;

   logic [2:0]                         state_ff, state_in;
   logic [rsos_pkg::SAMPLE_W-1:0]      thresh_ff, thresh_in;

   // sweep state
   logic                               in_object_ff, in_object_in;
   logic [A_W-1:0]                     run_start_ff, run_start_in;
   logic [rsos_pkg::SUM_W-1:0]         dist_sum_ff, dist_sum_in;
   logic [N_W-1:0]                     obj_total_ff, obj_total_in;
   logic [rsos_pkg::WIDTH_W-1:0]       narrow_w_ff, narrow_w_in;
   logic [N_W-1:0]                     narrow_id_ff, narrow_id_in;

   // per object work registers
   logic                               last_pend_ff, last_pend_in;
   logic [A_W-1:0]                     obj_start_ff, obj_start_in;
   logic [A_W-1:0]                     obj_end_ff, obj_end_in;
   logic [A_W-1:0]                     span_ff, span_in;
   logic [N_W-1:0]                     obj_num_ff, obj_num_in;
   logic [rsos_pkg::AVG_W-1:0]         avg_ff, avg_in;
   logic [rsos_pkg::SPAN_PROD_W-1:0]   prod1_ff, prod1_in;
   logic [rsos_pkg::SCALE_PROD_W-1:0]  prod2_ff, prod2_in;
   logic [rsos_pkg::WIDTH_W-1:0]       width_ff, width_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [rsos_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                               rsp_kind_ff, rsp_kind_in;
   logic                               rsp_last_ff, rsp_last_in;

   // sample fields and decode
   logic [rsos_pkg::SAMPLE_W-1:0]      sample_dist;
   logic [A_W-1:0]                     angle;
   logic                               accept;
   logic                               clear;
   logic                               in_obj_c;
   logic [A_W-1:0]                     start_c;
   logic [rsos_pkg::SUM_W-1:0]         sum_c;
   logic [N_W-1:0]                     total_c;
   logic                               in_range;
   logic                               is_near;
   logic                               closing;
   logic [rsos_pkg::SUM_W:0]           sum_add;
   logic [rsos_pkg::SUM_W-1:0]         sum_base;
   logic [N_W-1:0]                     num_c;
   logic [A_W:0]                       center_sum;
   logic [rsos_pkg::SCALE_PROD_W:0]    rounded_sum;
   logic [rsos_pkg::ROUNDED_W-1:0]     rounded;
   logic                               slot_free;
   logic                               csr_write;
   logic                               div_done;
   logic [rsos_pkg::SUM_W-1:0]         div_quo;

   assign sample_dist = req_tdata[rsos_pkg::SAMPLE_W-1:0];
   assign angle       = req_tdata[rsos_pkg::REQ_DATA_W-1:rsos_pkg::SAMPLE_W];
   assign accept      = req_tvalid && req_tready;

   assign req_tready = (state_ff == S_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      thresh_in = thresh_ff;
      if (csr_write && (csr_paddr[2] == rsos_pkg::REG_NEAR_THRESHOLD))
         thresh_in = csr_pwdata[rsos_pkg::SAMPLE_W-1:0];
      csr_prdata = '0;
      if (csr_paddr[2] == rsos_pkg::REG_NEAR_THRESHOLD)
         csr_prdata = rsos_pkg::CSR_DATA_W'(thresh_ff);
   end

   // sweep state as seen after an angle-zero clear
   always_comb begin
      clear    = (angle == '0);
      in_obj_c = clear ? 1'b0 : in_object_ff;
      start_c  = clear ? '0 : run_start_ff;
      sum_c    = clear ? '0 : dist_sum_ff;
      total_c  = clear ? '0 : obj_total_ff;
      in_range = ({1'b0, angle} < rsos_pkg::SWEEP_LIMIT);
      is_near  = (sample_dist < thresh_ff);
      closing  = in_range && !is_near && in_obj_c && (angle > start_c);
      sum_base = in_obj_c ? sum_c : '0;
      sum_add  = {1'b0, sum_base} + (rsos_pkg::SUM_W + 1)'(sample_dist);
      num_c    = (total_c == rsos_pkg::COUNT_MAX) ? rsos_pkg::COUNT_MAX : total_c + 1'b1;
   end

   rsos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && closing),
      .dividend (sum_c),
      .divisor  (angle - start_c),
      .done     (div_done),
      .quotient (div_quo)
   );

   // width rounding: (prod + half) >> 24, then saturate
   always_comb begin
      rounded_sum = {1'b0, prod2_ff} + rsos_pkg::ROUND_HALF;
      rounded     = rounded_sum[rsos_pkg::SCALE_PROD_W:rsos_pkg::FRAC_BITS];
      center_sum  = {1'b0, obj_start_ff} + {1'b0, obj_end_ff};
   end

   // sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      in_object_in = in_object_ff;
      run_start_in = run_start_ff;
      dist_sum_in  = dist_sum_ff;
      obj_total_in = obj_total_ff;
      narrow_w_in  = narrow_w_ff;
      narrow_id_in = narrow_id_ff;
      last_pend_in = last_pend_ff;
      obj_start_in = obj_start_ff;
      obj_end_in   = obj_end_ff;
      span_in      = span_ff;
      obj_num_in   = obj_num_ff;
      avg_in       = avg_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      width_in     = width_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               in_object_in = in_obj_c;
               run_start_in = start_c;
               dist_sum_in  = sum_c;
               obj_total_in = total_c;
               if (clear) begin
                  narrow_w_in  = rsos_pkg::WIDTH_MAX;
                  narrow_id_in = '0;
               end
               if (in_range && is_near) begin
                  in_object_in = 1'b1;
                  if (!in_obj_c)
                     run_start_in = angle;
                  dist_sum_in = sum_add[rsos_pkg::SUM_W] ? rsos_pkg::SUM_MAX
                                : sum_add[rsos_pkg::SUM_W-1:0];
               end else if (in_range && in_obj_c) begin
                  dist_sum_in = '0;
                  if (closing)
                     in_object_in = 1'b0;
               end
               // an open run is dropped at sweep end
               if (req_tlast) begin
                  in_object_in = 1'b0;
                  dist_sum_in  = '0;
               end
               last_pend_in = req_tlast;
               obj_start_in = start_c;
               obj_end_in   = angle;
               span_in      = angle - start_c;
               obj_num_in   = num_c;
               if (closing) begin
                  obj_total_in = num_c;
                  state_in     = S_DIV;
               end else if (req_tlast) begin
                  state_in = S_SUM;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               avg_in   = (div_quo[rsos_pkg::SUM_W-1:rsos_pkg::AVG_W] != '0)
                          ? rsos_pkg::AVG_MAX : div_quo[rsos_pkg::AVG_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod1_in = {{A_W{1'b0}}, avg_ff} * {{rsos_pkg::AVG_W{1'b0}}, span_ff};
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod2_in = rsos_pkg::SCALE_PROD_W'(prod1_ff) *
                       rsos_pkg::SCALE_PROD_W'(rsos_pkg::DEG_TO_RAD_Q24);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            width_in = (rounded[rsos_pkg::ROUNDED_W-1:rsos_pkg::WIDTH_W] != '0)
                       ? rsos_pkg::WIDTH_MAX : rounded[rsos_pkg::WIDTH_W-1:0];
            state_in = S_OBJ;
         end
         S_OBJ: begin
            if (slot_free) begin
               // first object seeds the search, later ones must be narrower
               if ((narrow_id_ff == '0) || (width_ff < narrow_w_ff)) begin
                  narrow_w_in  = width_ff;
                  narrow_id_in = obj_num_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_kind_in  = rsos_pkg::KIND_OBJECT;
               rsp_last_in  = !last_pend_ff;
               rsp_data_in  = rsos_pkg::RSP_DATA_W'({
                                 {N_W{1'b0}}, {N_W{1'b0}}, width_ff, avg_ff,
                                 center_sum[A_W:1], obj_end_ff, obj_start_ff, obj_num_ff});
               state_in     = last_pend_ff ? S_SUM : S_IDLE;
            end
         end
         S_SUM: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = rsos_pkg::KIND_SUMMARY;
               rsp_last_in  = 1'b1;
               rsp_data_in  = rsos_pkg::RSP_DATA_W'({
                                 narrow_id_ff, obj_total_ff, {rsos_pkg::WIDTH_W{1'b0}},
                                 {rsos_pkg::AVG_W{1'b0}}, {(3 * A_W){1'b0}}, {N_W{1'b0}}});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and sweep state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thresh_ff    <= rsos_pkg::THRESH_RESET;
         in_object_ff <= 1'b0;
         run_start_ff <= '0;
         dist_sum_ff  <= '0;
         obj_total_ff <= '0;
         narrow_w_ff  <= rsos_pkg::WIDTH_MAX;
         narrow_id_ff <= '0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         in_object_ff <= in_object_in;
         run_start_ff <= run_start_in;
         dist_sum_ff  <= dist_sum_in;
         obj_total_ff <= obj_total_in;
         narrow_w_ff  <= narrow_w_in;
         narrow_id_ff <= narrow_id_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      obj_start_ff <= obj_start_in;
      obj_end_ff   <= obj_end_in;
      span_ff      <= span_in;
      obj_num_ff   <= obj_num_in;
      avg_ff       <= avg_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
      width_ff     <= width_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== verif/range_sweep_object_segmenter_checker.sv =====
// ----------------------------------------------------------------------------
// range_sweep_object_segmenter_checker
// Watches the sample, result and register channels of the object segmenter,
// predicts the object records and sweep summaries each accepted sample
// causes, and compares every accepted result field by field in order.
// ----------------------------------------------------------------------------
module range_sweep_object_segmenter_checker
   import rsos_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    records_due,
   output int                    mismatches
);

   localparam logic [CSR_ADDR_W-1:0] THRESH_ADDR = CSR_ADDR_W'(4 * REG_NEAR_THRESHOLD);
   localparam logic [63:0] DEG_Q24 = 64'd292818;

   // one result as the block should deliver it
   typedef struct packed {
      logic               kind;
      logic [NUM_W-1:0]   number;
      logic [ANGLE_W-1:0] first_angle;
      logic [ANGLE_W-1:0] stop_angle;
      logic [ANGLE_W-1:0] mid_angle;
      logic [AVG_W-1:0]   mean_dist;
      logic [WIDTH_W-1:0] arc_width;
      logic [NUM_W-1:0]   count;
      logic [NUM_W-1:0]   narrowest;
      logic               final_one;
   } sweep_record_type;

   // result tdata layout, highest field first
   typedef struct packed {
      logic [RSP_DATA_W-RSP_BITS_W-1:0] pad;
      logic [NUM_W-1:0]                 narrowest;
      logic [NUM_W-1:0]                 count;
      logic [WIDTH_W-1:0]               arc_width;
      logic [AVG_W-1:0]                 mean_dist;
      logic [ANGLE_W-1:0]               mid_angle;
      logic [ANGLE_W-1:0]               stop_angle;
      logic [ANGLE_W-1:0]               first_angle;
      logic [NUM_W-1:0]                 number;
   } rsp_fields_type;

   // segmenter state as predicted
   logic [SAMPLE_W-1:0] near_limit;
   logic                in_run;
   logic [ANGLE_W-1:0]  run_first;
   logic [SUM_W-1:0]    run_sum;
   logic [NUM_W-1:0]    closed_count;
   logic [WIDTH_W-1:0]  best_width;
   logic [NUM_W-1:0]    best_id;
   sweep_record_type    pending_records[$];
   int                  results_seen;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at result %0d: %s", results_seen, what);
   endtask

   task automatic compare_field(input string field, input int unsigned got_v,
                                input int unsigned want_v);
      if (got_v != want_v)
         report_mismatch($sformatf("%s got %0d want %0d", field, got_v, want_v));
   endtask

   task automatic clear_sweep();
      in_run       = 1'b0;
      run_first    = '0;
      run_sum      = '0;
      closed_count = '0;
      best_width   = WIDTH_MAX;
      best_id      = '0;
   endtask

   // apply one sample and queue the records it causes
   task automatic segment_sample(input logic [SAMPLE_W-1:0] sample_dist,
                                 input logic [ANGLE_W-1:0] angle, input logic last);
      sweep_record_type   rec;
      logic [SUM_W:0]     sum_next;
      logic [ANGLE_W-1:0] span;
      logic [SUM_W-1:0]   quotient;
      logic [AVG_W-1:0]   mean;
      logic [63:0]        scaled;
      logic [WIDTH_W-1:0] arc;
      logic [NUM_W-1:0]   num;
      logic [ANGLE_W:0]   mid;
      if (angle == '0)
         clear_sweep();
      if (int'(angle) < SWEEP_SAMPLES) begin
         if (sample_dist < near_limit) begin
            // near sample: open a run if needed and accumulate
            if (!in_run) begin
               in_run    = 1'b1;
               run_first = angle;
               run_sum   = '0;
            end
            sum_next = {1'b0, run_sum} + {9'd0, sample_dist};
            run_sum  = (sum_next > {1'b0, SUM_MAX}) ? SUM_MAX : sum_next[SUM_W-1:0];
         end else if (in_run) begin
            // far sample closes the run only past its start
            if (angle > run_first) begin
               span     = angle - run_first;
               quotient = run_sum / span;
               mean     = (quotient > {8'd0, AVG_MAX}) ? AVG_MAX : quotient[AVG_W-1:0];
               scaled   = ({48'd0, mean} * {56'd0, span} * DEG_Q24 + 64'd8388608) >> 24;
               arc      = (scaled > {46'd0, WIDTH_MAX}) ? WIDTH_MAX : scaled[WIDTH_W-1:0];
               num      = (closed_count == COUNT_MAX) ? COUNT_MAX : closed_count + 1'b1;
               if (best_id == '0 || arc < best_width) begin
                  best_width = arc;
                  best_id    = num;
               end
               closed_count    = num;
               mid             = {1'b0, run_first} + {1'b0, angle};
               rec             = '0;
               rec.kind        = KIND_OBJECT;
               rec.number      = num;
               rec.first_angle = run_first;
               rec.stop_angle  = angle;
               rec.mid_angle   = mid[ANGLE_W:1];
               rec.mean_dist   = mean;
               rec.arc_width   = arc;
               rec.final_one   = !last;
               pending_records.push_back(rec);
               in_run = 1'b0;
            end
            run_sum = '0;
         end
      end
      // sweep end: summary, open run dropped
      if (last) begin
         rec           = '0;
         rec.kind      = KIND_SUMMARY;
         rec.count     = closed_count;
         rec.narrowest = best_id;
         rec.final_one = 1'b1;
         pending_records.push_back(rec);
         in_run  = 1'b0;
         run_sum = '0;
      end
   endtask

   // channel monitor
   always @(posedge clock) begin
      rsp_fields_type   got;
      sweep_record_type want;
      if (reset) begin
         near_limit = THRESH_RESET;
         clear_sweep();
         pending_records.delete();
      end else begin
         // register transactions
         if (csr_psel && csr_penable && csr_pready && csr_paddr == THRESH_ADDR) begin
            if (csr_pwrite)
               near_limit = csr_pwdata[SAMPLE_W-1:0];
            else
               compare_field("near_threshold readback", csr_prdata, {16'd0, near_limit});
         end
         // result transaction against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_records.size() == 0) begin
               report_mismatch("result with no record outstanding");
            end else begin
               want = pending_records.pop_front();
               compare_field("record_kind", rsp_tuser, want.kind);
               compare_field("object_number", got.number, want.number);
               compare_field("start_angle", got.first_angle, want.first_angle);
               compare_field("end_angle", got.stop_angle, want.stop_angle);
               compare_field("center_angle", got.mid_angle, want.mid_angle);
               compare_field("average_distance", got.mean_dist, want.mean_dist);
               compare_field("linear_width", got.arc_width, want.arc_width);
               compare_field("objects_found", got.count, want.count);
               compare_field("narrowest_number", got.narrowest, want.narrowest);
               compare_field("last_of_run", rsp_tlast, want.final_one);
               compare_field("tdata padding", got.pad, 0);
            end
            results_seen++;
         end
         // sample transaction
         if (req_tvalid && req_tready)
            segment_sample(req_tdata[SAMPLE_W-1:0], req_tdata[REQ_DATA_W-1:SAMPLE_W],
                           req_tlast);
      end
      records_due <= pending_records.size();
   end

endmodule

// ===== verif/range_sweep_object_segmenter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// range_sweep_object_segmenter_unit_tb
// Drives range samples into the object segmenter: a directed sweep over the
// corner cases, then random sweeps under several thresholds and idle
// patterns, with a long result hold-off, a saturating sum and a crowded
// sweep. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module range_sweep_object_segmenter_unit_tb;
   import rsos_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] THRESH_ADDR = CSR_ADDR_W'(4 * REG_NEAR_THRESHOLD);
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASES          = 7;
   localparam int PHASE_SAMPLES   = 85;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    records_due;
   int                    mismatches;
   int                    idle_pct = 0;
   int                    stall_pct = 0;
   logic                  hold_off_req = 1'b0;
   logic                  hold_off_ack = 1'b0;
   int                    samples_sent = 0;
   int                    quiet_cycles = 0;
   logic [SAMPLE_W-1:0]   near_setting = THRESH_RESET;
   logic [SAMPLE_W-1:0]   phase_limits [PHASES] = '{16'd65535, 16'd3000, 16'd0, 16'd1,
                                                   16'd0, 16'd720, 16'd40000};

   range_sweep_object_segmenter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   range_sweep_object_segmenter_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .records_due (records_due),
      .mismatches  (mismatches)
   );

   // clock
   always #5 clock = ~clock;

   // result side: random stalls, or one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_req && !hold_off_ack) begin
         hold_off_ack <= 1'b1;
         rsp_tready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one sample, with random idle cycles first
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample_dist,
                              input logic [ANGLE_W-1:0] angle, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {angle, sample_dist};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   // stop offering and wait for every outstanding record, then let the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (records_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register transaction: setup then access
   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= THRESH_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_distance(input logic near);
      if (near && near_setting != '0) begin
         case ($urandom_range(7))
            0:       return '0;
            1:       return near_setting - 1'b1;
            default: return SAMPLE_W'($urandom_range(near_setting - 1, 0));
         endcase
      end
      case ($urandom_range(7))
         0:       return near_setting;
         1:       return '1;
         default: return SAMPLE_W'($urandom_range(65535, near_setting));
      endcase
   endfunction

   // sweep from angle 0 with random runs, some noise, mostly closed by a last
   task automatic random_sweep();
      int   length;
      int   a;
      logic near_now;
      length   = ($urandom_range(9) == 0) ? $urandom_range(SWEEP_SAMPLES, 120)
                                          : $urandom_range(24, 2);
      near_now = 1'($urandom_range(1));
      for (a = 0; a < length; a++) begin
         if ($urandom_range(99) < 6)
            send_sample(SAMPLE_W'($urandom_range(65535)), ANGLE_W'($urandom_range(255)),
                        $urandom_range(7) == 0);
         if ($urandom_range(99) < 30)
            near_now = !near_now;
         send_sample(pick_distance(near_now), a[ANGLE_W-1:0],
                     (a == length - 1) && ($urandom_range(19) != 0));
      end
   endtask

   // stimulus
   initial begin
      int   phase;
      int   target;
      int   i;
      logic paused;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sweep at the reset threshold
      send_sample(16'd0, 8'd0, 1'b0);
      send_sample(16'd100, 8'd1, 1'b0);
      send_sample(16'd65535, 8'd2, 1'b0);
      send_sample(16'd719, 8'd3, 1'b0);
      send_sample(16'd720, 8'd4, 1'b0);
      send_sample(16'd50, 8'd5, 1'b0);
      // angles outside the sweep are ignored
      send_sample(16'd10, 8'd200, 1'b0);
      send_sample(16'd10, 8'd255, 1'b0);
      send_sample(16'd30000, 8'd181, 1'b0);
      send_sample(16'd30000, 8'd180, 1'b0);
      // far sample not past the run start keeps the run open and clears its sum
      send_sample(16'd1, 8'd20, 1'b0);
      send_sample(16'd800, 8'd20, 1'b0);
      send_sample(16'd800, 8'd15, 1'b0);
      send_sample(16'd5, 8'd21, 1'b0);
      send_sample(16'd800, 8'd22, 1'b0);
      // object closed by the last sample, then an open run dropped at sweep end
      send_sample(16'd3, 8'd30, 1'b0);
      send_sample(16'd900, 8'd31, 1'b1);
      send_sample(16'd3, 8'd40, 1'b1);
      send_sample(16'd900, 8'd41, 1'b0);
      // summary from an ignored angle, and from angle 0 itself
      send_sample(16'd2, 8'd250, 1'b1);
      send_sample(16'd0, 8'd0, 1'b1);
      send_sample(16'd720, 8'd0, 1'b1);
      drain_results();

      paused = 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         near_setting = (phase == 4) ? SAMPLE_W'($urandom_range(65535)) : phase_limits[phase];
         csr_access(1'b1, {16'd0, near_setting});
         csr_access(1'b0, '0);
         case (phase % 4)
            0:       begin idle_pct = 0;  stall_pct <= 0;  end
            1:       begin idle_pct = 52; stall_pct <= 0;  end
            2:       begin idle_pct = 0;  stall_pct <= 52; end
            default: begin idle_pct = 33; stall_pct <= 33; end
         endcase
         // long result hold-off while samples keep coming
         if (phase == 0)
            hold_off_req <= 1'b1;
         target = samples_sent + PHASE_SAMPLES;
         while (samples_sent < target) begin
            random_sweep();
            if (phase == 2 && !paused) begin
               drain_results();
               paused = 1'b1;
            end
         end
         // saturating sum and average on one angle, threshold at its maximum
         if (phase == 0) begin
            send_sample(16'd65535, 8'd0, 1'b0);
            for (i = 0; i < 258; i++)
               send_sample(16'd65534 - SAMPLE_W'($urandom_range(300)), 8'd5, 1'b0);
            send_sample(16'd65535, 8'd6, 1'b0);
            send_sample(16'd0, 8'd7, 1'b1);
         end
         // more objects than the count holds
         if (phase == PHASES - 1) begin
            send_sample(16'd65535, 8'd0, 1'b0);
            for (i = 0; i < 130; i++) begin
               send_sample(pick_distance(1'b1), 8'd1, 1'b0);
               send_sample(pick_distance(1'b0), 8'd2, 1'b0);
            end
            send_sample(16'd65535, 8'd3, 1'b1);
         end
         drain_results();
      end

      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
